// File: rtl/tcce_pkg.sv
package tcce_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int FUNC_W = 3;
  localparam int CHAR_W = 8;
  localparam int CARG_W = 8;
  localparam int RARG_W = 6;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam int TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7f;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;

  localparam logic [FUNC_W-1:0] FN_PUT      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MOVE     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLR_SCR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLR_LINE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLR_REST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_READ     = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DRAIN,
    ST_RDWAIT,
    ST_ADDR,
    ST_RESP
  } st_t;

  typedef enum logic [1:0] {
    WK_ZERO,
    WK_BLANK,
    WK_SCROLL
  } wk_mode_t;

  typedef struct packed {
    logic        [FUNC_W-1:0] func;
    logic        [CHAR_W-1:0] char_code;
    logic signed [CARG_W-1:0] col_arg;
    logic signed [RARG_W-1:0] row_arg;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_address;
    logic [CELL_W-1:0] cell_data;
  } res_t;

endpackage

// File: rtl/tcce_ifs.sv
interface tcce_in_if;
  import tcce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [FUNC_W-1:0] func;
  logic        [CHAR_W-1:0] char_code;
  logic signed [CARG_W-1:0] col_arg;
  logic signed [RARG_W-1:0] row_arg;

  modport source (output valid, func, char_code, col_arg, row_arg, input ready);
  modport sink   (input valid, func, char_code, col_arg, row_arg, output ready);
endinterface

interface tcce_out_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_address;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_col, cursor_row, cursor_address, cell_data, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_address, cell_data, output ready);
endinterface

// File: rtl/tcce_mem.sv
module tcce_mem #(
  parameter int DEPTH = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tcce_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [tcce_pkg::CELL_W-1:0] rdata
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem_r [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tcce_addr.sv
module tcce_addr #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic [tcce_pkg::COL_W-1:0] col,
  input  logic [tcce_pkg::ROW_W-1:0] row,
  output logic [AW-1:0]              addr
);
  import tcce_pkg::*;

  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic [AW-1:0] row_base;

  // row times line length, then column offset
  assign row_base = AW'(AW'(row) * COLS_A);
  assign addr     = row_base + AW'(col);

endmodule

// File: rtl/tcce_ctrl.sv
module tcce_ctrl #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  output logic                        in_rdy,
  input  tcce_pkg::in_item_t          in_item,
  output logic                        res_vld,
  input  logic                        res_rdy,
  output tcce_pkg::res_t              res,
  output logic [tcce_pkg::COL_W-1:0]  au_col,
  output logic [tcce_pkg::ROW_W-1:0]  au_row,
  input  logic [AW-1:0]               au_addr,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [tcce_pkg::CELL_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [tcce_pkg::CELL_W-1:0] mem_rdata
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CS_W  = COL_W + 3;
  localparam int RS_W  = ROW_W + 3;
  localparam int CA_W  = COL_W + 1;

  localparam logic [AW-1:0]          LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]          SCROLL_LIM = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]          COLS_A     = AW'(COLUMNS);
  localparam logic [COL_W-1:0]       COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]       ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [CA_W-1:0]        COLS_CA    = CA_W'(COLUMNS);
  localparam logic [CA_W-1:0]        TAB_MASK   = CA_W'(TAB_STEP - 1);
  localparam logic signed [CS_W-1:0] COL_MAX_S  = CS_W'(COLUMNS - 1);
  localparam logic signed [RS_W-1:0] ROW_MAX_S  = RS_W'(ROWS - 1);

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [CS_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > COL_MAX_S) begin
      r = COL_LAST;
    end else begin
      r = v[COL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [RS_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ROW_MAX_S) begin
      r = ROW_LAST;
    end else begin
      r = v[ROW_W-1:0];
    end
    return r;
  endfunction

  st_t               state_r, state_nxt;
  in_item_t          in_r, in_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [AW-1:0]     cur_addr_r, cur_addr_nxt;
  logic [AW-1:0]     wk_addr_r, wk_addr_nxt;
  logic [AW-1:0]     wk_last_r, wk_last_nxt;
  wk_mode_t          wk_mode_r, wk_mode_nxt;
  logic [CHAR_W-1:0] fill_r, fill_nxt;
  logic              scroll_pend_r, scroll_pend_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              pend_copy_r, pend_copy_nxt;

  logic [COL_W-1:0]       set_col, mv_col_c, dec_col;
  logic [ROW_W-1:0]       set_row, mv_row_c, dec_row;
  logic signed [CS_W-1:0] mv_col;
  logic signed [RS_W-1:0] mv_row;
  logic [CA_W-1:0]        adv_col, tab_col;
  logic [AW-1:0]          bs_addr;
  logic                   printable, put_nl;
  logic                   dec_walk, dec_scroll_pend;
  logic [AW-1:0]          dec_start, dec_last;
  wk_mode_t               dec_mode;
  logic [CHAR_W-1:0]      dec_fill;
  logic                   wk_end, wk_copy;
  logic [AW-1:0]          wk_raddr;

  assign set_col = clamp_col({{(CS_W-CARG_W){in_r.col_arg[CARG_W-1]}}, in_r.col_arg});
  assign set_row = clamp_row({{(RS_W-RARG_W){in_r.row_arg[RARG_W-1]}}, in_r.row_arg});

  assign mv_col = $signed({{(CS_W-COL_W){1'b0}}, cur_col_r})
                + $signed({{(CS_W-CARG_W){in_r.col_arg[CARG_W-1]}}, in_r.col_arg});
  assign mv_row = $signed({{(RS_W-ROW_W){1'b0}}, cur_row_r})
                + $signed({{(RS_W-RARG_W){in_r.row_arg[RARG_W-1]}}, in_r.row_arg});
  assign mv_col_c = clamp_col(mv_col);
  assign mv_row_c = clamp_row(mv_row);

  assign adv_col   = {1'b0, cur_col_r} + CA_W'(1);
  assign tab_col   = ({1'b0, cur_col_r} | TAB_MASK) + CA_W'(1);
  assign bs_addr   = (cur_addr_r == '0) ? '0 : cur_addr_r - AW'(1);
  assign printable = (in_r.char_code >= PRINT_LO) && (in_r.char_code <= PRINT_HI);

  // scroll copies from the row below, the last row keeps its attribute
  assign wk_copy  = (wk_mode_r == WK_SCROLL) && (wk_addr_r < SCROLL_LIM);
  assign wk_raddr = wk_copy ? wk_addr_r + COLS_A : wk_addr_r;
  assign wk_end   = (wk_addr_r == wk_last_r);

  // function decode
  always_comb begin
    dec_walk        = 1'b0;
    dec_start       = cur_addr_r;
    dec_last        = cur_addr_r;
    dec_mode        = WK_BLANK;
    dec_fill        = SPACE_CODE;
    dec_scroll_pend = 1'b0;
    dec_col         = cur_col_r;
    dec_row         = cur_row_r;
    put_nl          = 1'b0;
    case (in_r.func)
      FN_PUT: begin
        if (printable) begin
          dec_walk = 1'b1;
          dec_fill = in_r.char_code;
          if (adv_col >= COLS_CA) begin
            put_nl = 1'b1;
          end else begin
            dec_col = adv_col[COL_W-1:0];
          end
        end else if (in_r.char_code == CH_NL) begin
          put_nl = 1'b1;
        end else if (in_r.char_code == CH_TAB) begin
          if (tab_col >= COLS_CA) begin
            put_nl = 1'b1;
          end else begin
            dec_col = tab_col[COL_W-1:0];
          end
        end else if (in_r.char_code == CH_BS) begin
          dec_walk  = 1'b1;
          dec_start = bs_addr;
          dec_last  = bs_addr;
          if (cur_col_r != '0) begin
            dec_col = cur_col_r - COL_W'(1);
          end else if (cur_row_r != '0) begin
            dec_col = COL_LAST;
            dec_row = cur_row_r - ROW_W'(1);
          end
        end
        if (put_nl) begin
          dec_col = '0;
          if (cur_row_r == ROW_LAST) begin
            if (dec_walk) begin
              dec_scroll_pend = 1'b1;
            end else begin
              dec_walk  = 1'b1;
              dec_start = '0;
              dec_last  = LAST_CELL;
              dec_mode  = WK_SCROLL;
            end
          end else begin
            dec_row = cur_row_r + ROW_W'(1);
          end
        end
      end
      FN_SET: begin
        dec_col = set_col;
        dec_row = set_row;
      end
      FN_MOVE: begin
        dec_col = mv_col_c;
        dec_row = mv_row_c;
      end
      FN_CLR_SCR: begin
        dec_walk  = 1'b1;
        dec_start = '0;
        dec_last  = LAST_CELL;
        dec_col   = '0;
        dec_row   = '0;
      end
      FN_CLR_LINE: begin
        if (cur_col_r != COL_LAST) begin
          dec_walk  = 1'b1;
          dec_start = cur_addr_r + AW'(1);
          dec_last  = cur_addr_r + AW'(COL_LAST - cur_col_r);
        end
      end
      FN_CLR_REST: begin
        if (cur_addr_r != LAST_CELL) begin
          dec_walk  = 1'b1;
          dec_start = cur_addr_r + AW'(1);
          dec_last  = LAST_CELL;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_vld) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (dec_walk) begin
          state_nxt = ST_WALK;
        end else if (in_r.func == FN_READ) begin
          state_nxt = ST_RDWAIT;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_WALK: begin
        if (wk_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (wk_mode_r == WK_ZERO) begin
          state_nxt = ST_IDLE;
        end else if (scroll_pend_r) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_RDWAIT: state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_rdy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_nxt          = in_r;
    cell_nxt        = cell_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    cur_addr_nxt    = cur_addr_r;
    wk_addr_nxt     = wk_addr_r;
    wk_last_nxt     = wk_last_r;
    wk_mode_nxt     = wk_mode_r;
    fill_nxt        = fill_r;
    scroll_pend_nxt = scroll_pend_r;
    pend_vld_nxt    = 1'b0;
    pend_addr_nxt   = wk_addr_r;
    pend_copy_nxt   = wk_copy;
    in_rdy          = (state_r == ST_IDLE);
    res_vld         = (state_r == ST_RESP);
    au_col          = cur_col_r;
    au_row          = cur_row_r;
    mem_raddr       = wk_raddr;
    case (state_r)
      ST_IDLE: begin
        if (in_vld) begin
          in_nxt   = in_item;
          cell_nxt = '0;
        end
      end
      ST_EXEC: begin
        au_col          = set_col;
        au_row          = set_row;
        mem_raddr       = au_addr;
        cur_col_nxt     = dec_col;
        cur_row_nxt     = dec_row;
        wk_addr_nxt     = dec_start;
        wk_last_nxt     = dec_last;
        wk_mode_nxt     = dec_mode;
        fill_nxt        = dec_fill;
        scroll_pend_nxt = dec_scroll_pend;
      end
      ST_WALK: begin
        pend_vld_nxt = 1'b1;
        if (!wk_end) begin
          wk_addr_nxt = wk_addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (scroll_pend_r && (wk_mode_r != WK_ZERO)) begin
          wk_addr_nxt     = '0;
          wk_last_nxt     = LAST_CELL;
          wk_mode_nxt     = WK_SCROLL;
          fill_nxt        = SPACE_CODE;
          scroll_pend_nxt = 1'b0;
        end
      end
      ST_RDWAIT: cell_nxt = mem_rdata;
      ST_ADDR:   cur_addr_nxt = au_addr;
      default: begin
      end
    endcase
  end

  // write side of the walk, one cell behind the read
  assign mem_we    = pend_vld_r;
  assign mem_waddr = pend_addr_r;
  always_comb begin
    if (wk_mode_r == WK_ZERO) begin
      mem_wdata = '0;
    end else if (pend_copy_r) begin
      mem_wdata = mem_rdata;
    end else begin
      mem_wdata = {mem_rdata[CELL_W-1:CHAR_W], fill_r};
    end
  end

  assign res.cursor_col     = cur_col_r;
  assign res.cursor_row     = cur_row_r;
  assign res.cursor_address = ADDR_W'(cur_addr_r);
  assign res.cell_data      = cell_r;

  // reset starts a zero-fill walk over the whole memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_WALK;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      cur_addr_r    <= '0;
      wk_addr_r     <= '0;
      wk_last_r     <= LAST_CELL;
      wk_mode_r     <= WK_ZERO;
      scroll_pend_r <= 1'b0;
      pend_vld_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_addr_r    <= cur_addr_nxt;
      wk_addr_r     <= wk_addr_nxt;
      wk_last_r     <= wk_last_nxt;
      wk_mode_r     <= wk_mode_nxt;
      scroll_pend_r <= scroll_pend_nxt;
      pend_vld_r    <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    cell_r      <= cell_nxt;
    fill_r      <= fill_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_copy_r <= pend_copy_nxt;
  end

endmodule

// File: rtl/text_console_cursor_engine.sv
// channel  dir  words                                      handshake
// in_ch    in   func, char_code, col_arg, row_arg         valid/ready
// out_ch   out  cursor_col, cursor_row, cursor_address,   valid/ready
//               cell_data
//
// set, move, newline, tab and ignored codes go through EXEC, ADDR and RESP;
// a read adds RDWAIT, a printable character or backspace a WALK and DRAIN of one cell;
// a scroll walks the whole memory, a clear the cells that it blanks,
// all at one cell per cycle in the walk over the text memory
// after reset a zero fill of the whole memory runs with in_ch.ready low
// one word at a time; the output register holds a result while the next word is taken
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcce_in_if.sink    in_ch,
  tcce_out_if.source out_ch
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  in_item_t          in_item;
  res_t              res, out_res_r;
  logic              res_vld, res_rdy, in_rdy;
  logic              out_vld_r, out_vld_nxt;
  logic [COL_W-1:0]  au_col;
  logic [ROW_W-1:0]  au_row;
  logic [AW-1:0]     au_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  assign in_item.func      = in_ch.func;
  assign in_item.char_code = in_ch.char_code;
  assign in_item.col_arg   = in_ch.col_arg;
  assign in_item.row_arg   = in_ch.row_arg;
  assign in_ch.ready       = in_rdy;

  tcce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_ch.valid),
    .in_rdy    (in_rdy),
    .in_item   (in_item),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res),
    .au_col    (au_col),
    .au_row    (au_row),
    .au_addr   (au_addr),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcce_addr #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_addr (
    .col  (au_col),
    .row  (au_row),
    .addr (au_addr)
  );

  tcce_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_rdy     = !out_vld_r || out_ch.ready;
  assign out_vld_nxt = res_vld || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.cursor_col     = out_res_r.cursor_col;
  assign out_ch.cursor_row     = out_res_r.cursor_row;
  assign out_ch.cursor_address = out_res_r.cursor_address;
  assign out_ch.cell_data      = out_res_r.cell_data;

endmodule

// File: rtl/tcce_chk.sv
module tcce_chk #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcce_pkg::COL_W-1:0]  out_cursor_col,
  input logic [tcce_pkg::ROW_W-1:0]  out_cursor_row,
  input logic [tcce_pkg::ADDR_W-1:0] out_cursor_address,
  input logic [tcce_pkg::CELL_W-1:0] out_cell_data
);
  import tcce_pkg::*;

  localparam int AX_W = COL_W + ROW_W + 8;

  logic [ADDR_W-1:0] exp_addr;

  assign exp_addr = ADDR_W'(AX_W'(out_cursor_col) + AX_W'(out_cursor_row) * AX_W'(COLUMNS));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_col)
      && $stable(out_cursor_row) && $stable(out_cursor_address) && $stable(out_cell_data))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_col < COL_W'(COLUMNS) && out_cursor_row < ROW_W'(ROWS)
      && out_cursor_address == exp_addr)
    else $error("cursor out of range or address mismatch");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during memory clear");

endmodule

bind text_console_cursor_engine tcce_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_cursor_col     (out_ch.cursor_col),
  .out_cursor_row     (out_ch.cursor_row),
  .out_cursor_address (out_ch.cursor_address),
  .out_cell_data      (out_ch.cell_data)
);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int RANDOM_WORDS = 1500;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 2 * (CELLS + 1) + 64;
  localparam int CYCLE_LIMIT = 3 * ((RANDOM_WORDS + 40) * (2 * CELLS + 48) + CELLS + 4000);

  localparam logic [FUNC_W-1:0] FN_NONE = 3'd7;

  class console_scoreboard;
    logic [CELL_W-1:0] screen[CELLS];
    int cur_col;
    int cur_row;
    res_t reports[$];
    int mismatches;
    int words;
    int checked;
    int scrolls;
    int clears;
    int reads;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      mismatches = 0;
      words = 0;
      checked = 0;
      scrolls = 0;
      clears = 0;
      reads = 0;
    endfunction

    function void write_low(int c, int r, logic [CHAR_W-1:0] ch);
      int a;
      a = c + r * COLS;
      if (a < CELLS) screen[a] = {screen[a][CELL_W-1:CHAR_W], ch};
    endfunction

    function void blank_from(int first, int r);
      for (int c = first; c < COLS; c++) write_low(c, r, SPACE_CODE);
    endfunction

    function void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        cur_row = ROWS - 1;
        for (int i = 0; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
        blank_from(0, ROWS - 1);
        scrolls++;
      end
    endfunction

    function int clamp(int v, int top);
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
    endfunction

    function void note_command(in_item_t w);
      int dc;
      int dr;
      int rc;
      int rr;
      logic [CELL_W-1:0] rd_data;
      res_t want;
      dc = $signed(w.col_arg);
      dr = $signed(w.row_arg);
      rd_data = '0;
      words++;
      case (w.func)
        FN_PUT: begin
          if (w.char_code >= PRINT_LO && w.char_code <= PRINT_HI) begin
            write_low(cur_col, cur_row, w.char_code);
            cur_col++;
            if (cur_col >= COLS) line_feed();
          end else if (w.char_code == CH_NL) begin
            line_feed();
          end else if (w.char_code == CH_TAB) begin
            cur_col += TAB_STEP - (cur_col % TAB_STEP);
            if (cur_col >= COLS) line_feed();
          end else if (w.char_code == CH_BS) begin
            if (cur_col == 0) begin
              if (cur_row > 0) begin
                cur_col = COLS - 1;
                cur_row--;
              end
            end else begin
              cur_col--;
            end
            write_low(cur_col, cur_row, SPACE_CODE);
          end
        end
        FN_SET: begin
          cur_col = clamp(dc, COLS - 1);
          cur_row = clamp(dr, ROWS - 1);
        end
        FN_MOVE: begin
          cur_col = clamp(cur_col + dc, COLS - 1);
          cur_row = clamp(cur_row + dr, ROWS - 1);
        end
        FN_CLR_SCR: begin
          for (int r = 0; r < ROWS; r++) blank_from(0, r);
          cur_col = 0;
          cur_row = 0;
          clears++;
        end
        FN_CLR_LINE: begin
          blank_from(cur_col + 1, cur_row);
          clears++;
        end
        FN_CLR_REST: begin
          blank_from(cur_col + 1, cur_row);
          for (int r = cur_row + 1; r < ROWS; r++) blank_from(0, r);
          clears++;
        end
        FN_READ: begin
          rc = clamp(dc, COLS - 1);
          rr = clamp(dr, ROWS - 1);
          rd_data = screen[(rc + rr * COLS) % CELLS];
          reads++;
        end
        default: begin
        end
      endcase
      want.cursor_col = COL_W'(cur_col);
      want.cursor_row = ROW_W'(cur_row);
      want.cursor_address = ADDR_W'(cur_col + cur_row * COLS);
      want.cell_data = rd_data;
      reports.push_back(want);
    endfunction

    function void check_report(res_t got);
      res_t want;
      checked++;
      if (reports.size() == 0) begin
        $error("result with no word pending: col %0d row %0d addr %0d cell %h",
               got.cursor_col, got.cursor_row, got.cursor_address, got.cell_data);
        mismatches++;
        return;
      end
      want = reports.pop_front();
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        mismatches++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        mismatches++;
      end
      if (got.cursor_address !== want.cursor_address) begin
        $error("cursor_address: expected %0d, got %0d", want.cursor_address,
               got.cursor_address);
        mismatches++;
      end
      if (got.cell_data !== want.cell_data) begin
        $error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int cycles = 0;
  int send_left = 0;
  bit send_calm = 1'b0;
  int take_left = 0;
  bit take_calm = 1'b0;
  console_scoreboard sb;

  tcce_in_if in_ch();
  tcce_out_if out_ch();

  text_console_cursor_engine uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** text_console_cursor_engine: FAILED **");
      $finish;
    end
  end

  // stretches of random gaps mix with stretches of back-to-back traffic
  function automatic int draw_gap(ref int left, ref bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_word(in_item_t w);
    int gap;
    gap = draw_gap(send_left, send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.func <= w.func;
    in_ch.char_code <= w.char_code;
    in_ch.col_arg <= w.col_arg;
    in_ch.row_arg <= w.row_arg;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_command(w);
  endtask

  task automatic send_op(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] ch, int c, int r);
    in_item_t w;
    w.func = fn;
    w.char_code = ch;
    w.col_arg = CARG_W'(c);
    w.row_arg = RARG_W'(r);
    send_word(w);
  endtask

  // result side, with one long hold-off to back the block up
  initial begin
    int gap;
    bit held;
    res_t got;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(take_left, take_calm);
      if (!held && sb.checked == 400) begin
        gap = LONG_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got.cursor_col = out_ch.cursor_col;
      got.cursor_row = out_ch.cursor_row;
      got.cursor_address = out_ch.cursor_address;
      got.cell_data = out_ch.cell_data;
      sb.check_report(got);
    end
  end

  initial begin
    in_item_t w;
    int pick;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_PUT;
    in_ch.char_code <= '0;
    in_ch.col_arg <= '0;
    in_ch.row_arg <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation, clamping, wrap, scroll and every function
    send_op(FN_READ, 8'h00, -128, -32);
    send_op(FN_READ, 8'hff, 127, 31);
    send_op(FN_SET, 8'h00, 127, 31);
    send_op(FN_PUT, 8'h41, 0, 0);
    send_op(FN_PUT, PRINT_HI, 0, 0);
    send_op(FN_PUT, 8'h00, 0, 0);
    send_op(FN_PUT, 8'h80, 0, 0);
    send_op(FN_PUT, 8'h1f, 0, 0);
    send_op(FN_SET, 8'h00, -128, -32);
    send_op(FN_PUT, CH_BS, 0, 0);
    send_op(FN_MOVE, 8'h00, 127, 31);
    send_op(FN_MOVE, 8'h00, -128, -32);
    send_op(FN_SET, 8'h00, 75, 3);
    send_op(FN_PUT, CH_TAB, 0, 0);
    send_op(FN_SET, 8'h00, 0, 5);
    send_op(FN_PUT, CH_BS, 0, 0);
    send_op(FN_PUT, CH_NL, 0, 0);
    send_op(FN_SET, 8'h00, 10, 24);
    send_op(FN_PUT, CH_NL, 0, 0);
    send_op(FN_SET, 8'h00, 40, 12);
    send_op(FN_CLR_LINE, 8'h00, 0, 0);
    send_op(FN_CLR_REST, 8'h00, 0, 0);
    send_op(FN_NONE, 8'h55, -1, -1);
    send_op(FN_READ, 8'h00, 40, 12);
    send_op(FN_CLR_SCR, 8'h00, 0, 0);

    // random: mostly running text with cursor control, some reads and clears
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      w.func = FN_PUT;
      w.char_code = CHAR_W'($urandom_range(0, 255));
      w.col_arg = CARG_W'($urandom_range(0, 255));
      w.row_arg = RARG_W'($urandom_range(0, 63));
      if (pick < 50) begin
        w.char_code = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
      end else if (pick < 55) begin
        w.char_code = CH_NL;
      end else if (pick < 60) begin
        w.char_code = CH_TAB;
      end else if (pick < 64) begin
        w.char_code = CH_BS;
      end else if (pick < 68) begin
      end else if (pick < 76) begin
        w.func = FN_SET;
        if ($urandom_range(0, 1) == 0) begin
          w.col_arg = CARG_W'($urandom_range(0, COLS - 1));
          w.row_arg = RARG_W'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 82) begin
        w.func = FN_MOVE;
        if ($urandom_range(0, 9) < 7) begin
          w.col_arg = CARG_W'(int'($urandom_range(0, 6)) - 3);
          w.row_arg = RARG_W'(int'($urandom_range(0, 4)) - 2);
        end
      end else if (pick < 94) begin
        w.func = FN_READ;
        if ($urandom_range(0, 9) < 6) begin
          w.col_arg = CARG_W'($urandom_range(0, COLS - 1));
          w.row_arg = RARG_W'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 96) begin
        w.func = FN_CLR_LINE;
      end else if (pick < 97) begin
        w.func = FN_CLR_REST;
      end else if (pick < 98) begin
        w.func = FN_CLR_SCR;
      end else if (pick < 99) begin
        w.func = FN_NONE;
      end else begin
        w.func = FUNC_W'($urandom_range(0, 7));
      end
      send_word(w);
    end
    in_ch.valid <= 1'b0;

    while (sb.reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d words, checked %0d results: %0d reads, %0d clears, %0d scrolls",
             sb.words, sb.checked, sb.reads, sb.clears, sb.scrolls);
    $display("result side held off once for %0d cycles, %0d mismatches",
             LONG_HOLD, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** text_console_cursor_engine: PASSED **");
    end else begin
      $display("** text_console_cursor_engine: FAILED **");
    end
    $finish;
  end
endmodule
